// ===== hw/rtl/psu_pkg.sv =====
package psu_pkg;

    localparam int MAX_LINE_BYTES_DEF  = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH         = 4;

    localparam int ROW_PIXELS_W = 13;
    localparam int IMAGE_ROWS_W = 16;
    localparam int BPP_W        = 3;

    localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RST = 13'd64;
    localparam logic [IMAGE_ROWS_W-1:0] IMAGE_ROWS_RST = 16'd64;
    localparam logic [BPP_W-1:0]        BPP_RST        = 3'd4;
    localparam logic [7:0]              BYTE_MASK      = 8'hFF;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_ROW_PIXELS = 2'd0,
        REG_IMAGE_ROWS = 2'd1,
        REG_BPP        = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Per-beat classification passed from the front to the back.
    typedef struct packed {
        t_filter filter;
        logic    bad;
        logic    first_row;
        logic    have_left;
        logic    eor;
        logic    eoi;
    } t_flags;

    // Paeth predictor: p = a + b - c, pick the closest of a, b, c.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/psu_if.sv =====
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_byte;

    modport source (output valid, output filtered_byte, input ready);
    modport sink (input valid, input filtered_byte, output ready);
endinterface

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       end_of_row;
    logic       end_of_image;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output end_of_row,
                    output end_of_image, output bad_filter, input ready);
    modport sink (input valid, input pixel_byte, input end_of_row,
                  input end_of_image, input bad_filter, output ready);
endinterface

// ===== hw/rtl/psu_front.sv =====
module psu_front #(
    parameter int MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
    parameter int CW              = $clog2(MAX_LINE_BYTES),
    parameter int PW              = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    psu_in_if.sink                            i_in,
    input  logic [psu_pkg::ROW_PIXELS_W-1:0]  i_row_pixels,
    input  logic [psu_pkg::IMAGE_ROWS_W-1:0]  i_image_rows,
    input  logic [psu_pkg::BPP_W-1:0]         i_bpp,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output psu_pkg::t_flags                   o_q_flags,
    output logic [7:0]                        o_q_byte,
    output logic [CW-1:0]                     o_q_col,
    output logic [PW-1:0]                     o_q_lidx
);

    localparam int BW = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int PRW = psu_pkg::ROW_PIXELS_W + BW;
    localparam int EW = (CW + 1 > PRW) ? CW + 1 : PRW;
    localparam int RW = psu_pkg::IMAGE_ROWS_W;

    logic              r_await;
    logic              n_await;
    logic [CW-1:0]     r_col;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     r_row;
    logic [RW-1:0]     n_row;
    psu_pkg::t_filter  r_filter;
    psu_pkg::t_filter  n_filter;
    logic              r_bad;
    logic              n_bad;

    logic              accept;
    logic [BW-1:0]     bpp_eff;
    logic [psu_pkg::ROW_PIXELS_W-1:0] pix_eff;
    logic [RW-1:0]     rows_eff;
    logic [PRW-1:0]    stride_raw;
    logic [EW-1:0]     col_next;
    logic              eor;
    logic              eoi;

    assign i_in.ready = r_await || !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_bpp == '0) begin
            bpp_eff = BW'(1);
        end else if (5'(i_bpp) > 5'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BW'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = BW'(i_bpp);
        end
    end

    assign pix_eff    = (i_row_pixels == '0) ? psu_pkg::ROW_PIXELS_W'(1) : i_row_pixels;
    assign rows_eff   = (i_image_rows == '0) ? RW'(1) : i_image_rows;
    assign stride_raw = PRW'(pix_eff) * PRW'(bpp_eff);
    assign col_next   = EW'(r_col) + EW'(1);

    // The stride clamps to the line store size, and the column never passes it.
    assign eor = (col_next >= EW'(stride_raw)) || (col_next >= EW'(MAX_LINE_BYTES));
    assign eoi = eor && ((17'(r_row) + 17'(1)) >= 17'(rows_eff));

    assign o_q_push            = accept && !r_await;
    assign o_q_byte            = i_in.filtered_byte;
    assign o_q_col             = r_col;
    assign o_q_lidx            = PW'(bpp_eff - BW'(1));
    assign o_q_flags.filter    = r_filter;
    assign o_q_flags.bad       = r_bad;
    assign o_q_flags.first_row = (r_row == '0);
    assign o_q_flags.have_left = (EW'(r_col) >= EW'(bpp_eff));
    assign o_q_flags.eor       = eor;
    assign o_q_flags.eoi       = eoi;

    always_comb begin
        n_await  = r_await;
        n_col    = r_col;
        n_row    = r_row;
        n_filter = r_filter;
        n_bad    = r_bad;
        if (accept) begin
            if (r_await) begin
                n_await = 1'b0;
                n_col   = '0;
                if (i_in.filtered_byte > 8'(psu_pkg::FILT_PAETH)) begin
                    n_bad    = 1'b1;
                    n_filter = psu_pkg::FILT_NONE;
                end else begin
                    n_bad    = 1'b0;
                    n_filter = psu_pkg::t_filter'(i_in.filtered_byte[2:0]);
                end
            end else if (eor) begin
                n_await = 1'b1;
                n_col   = '0;
                n_row   = eoi ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_col    <= '0;
            r_row    <= '0;
            r_filter <= psu_pkg::FILT_NONE;
            r_bad    <= 1'b0;
        end else begin
            r_await  <= n_await;
            r_col    <= n_col;
            r_row    <= n_row;
            r_filter <= n_filter;
            r_bad    <= n_bad;
        end
    end

endmodule

// ===== hw/rtl/psu_queue.sv =====
module psu_queue #(
    parameter int W     = 8,
    parameter int DEPTH = psu_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [NW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [NW-1:0] n_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/psu_back.sv =====
module psu_back #(
    parameter int MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
    parameter int CW              = $clog2(MAX_LINE_BYTES),
    parameter int PW              = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  psu_pkg::t_flags  i_q_flags,
    input  logic [7:0]       i_q_byte,
    input  logic [CW-1:0]    i_q_col,
    input  logic [PW-1:0]    i_q_lidx,
    output logic             o_q_pop,
    psu_out_if.source        o_out
);

    // Line store of the previous reconstructed row.
    logic [7:0]       r_line [MAX_LINE_BYTES];
    logic [7:0]       r_rd_data;
    logic             r_byp;
    logic [7:0]       r_byp_data;

    logic             r_s1_valid;
    psu_pkg::t_flags  r_s1_flags;
    logic [7:0]       r_s1_byte;
    logic [CW-1:0]    r_s1_col;
    logic [PW-1:0]    r_s1_lidx;

    logic [7:0]       r_left [MAX_PIXEL_BYTES];
    logic [7:0]       r_upleft [MAX_PIXEL_BYTES];

    logic             r_o_valid;
    logic [7:0]       r_o_pixel;
    logic             r_o_eor;
    logic             r_o_eoi;
    logic             r_o_bad;

    logic             advance;
    logic [7:0]       above_raw;
    logic [7:0]       above;
    logic [7:0]       left;
    logic [7:0]       upleft;
    logic [8:0]       avg_sum;
    logic [7:0]       pred;
    logic [7:0]       val;

    assign advance = r_s1_valid && (!r_o_valid || o_out.ready);
    assign o_q_pop = i_q_valid && (!r_s1_valid || advance);

    // A read at the column being written in the same cycle takes the new byte.
    assign above_raw = r_byp ? r_byp_data : r_rd_data;
    assign above     = r_s1_flags.first_row ? 8'd0 : above_raw;
    assign left      = r_s1_flags.have_left ? r_left[r_s1_lidx] : 8'd0;
    assign upleft    = (r_s1_flags.have_left && !r_s1_flags.first_row) ?
                       r_upleft[r_s1_lidx] : 8'd0;
    assign avg_sum   = 9'(left) + 9'(above);

    always_comb begin
        unique case (r_s1_flags.filter)
            psu_pkg::FILT_SUB:   pred = left;
            psu_pkg::FILT_UP:    pred = above;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(left, above, upleft);
            default:             pred = 8'd0;
        endcase
    end

    assign val = (r_s1_byte + pred) & psu_pkg::BYTE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_flags <= i_q_flags;
            r_s1_byte  <= i_q_byte;
            r_s1_col   <= i_q_col;
            r_s1_lidx  <= i_q_lidx;
            r_rd_data  <= r_line[i_q_col];
            r_byp      <= advance && (r_s1_col == i_q_col);
            r_byp_data <= val;
        end
        if (advance) begin
            r_line[r_s1_col] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_left[0]   <= val;
            r_upleft[0] <= above;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= r_left[i-1];
                r_upleft[i] <= r_upleft[i-1];
            end
            r_o_pixel <= val;
            r_o_eor   <= r_s1_flags.eor;
            r_o_eoi   <= r_s1_flags.eoi;
            r_o_bad   <= r_s1_flags.bad;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.pixel_byte   = r_o_pixel;
    assign o_out.end_of_row   = r_o_eor;
    assign o_out.end_of_image = r_o_eoi;
    assign o_out.bad_filter   = r_o_bad;

`ifndef ASSERT_OFF
    a_eoi_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_eoi) |-> r_o_eor)
        else $error("end of image without end of row");
`endif

endmodule

// ===== hw/rtl/png_scanline_unfilter.sv =====
// Channel   Dir  Beat payload                                     Handshake
// i_in      in   filtered_byte[7:0]                               valid/ready
// o_out     out  pixel_byte[7:0] end_of_row end_of_image bad_filter  valid/ready
// apb       in   row_pixels @0x0, image_rows @0x4, bytes_per_pixel @0x8
//
// One input beat per cycle is sustained while o_out is not stalled; the back loop
// (line store read, predictor, history update) keeps that pace for every beat.
// A data byte passes the queue, the stage-1 register and the output register before
// o_out.valid rises for it. Filter bytes produce no output beat. A four-entry queue lets
// the input keep flowing for a few beats while o_out is stalled. Reset is synchronous and
// needs no clearing pass; the line store holds garbage until the first row.
module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    psu_in_if.sink                      i_in,
    psu_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_LINE_BYTES);
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int QW = $bits(psu_pkg::t_flags) + 8 + CW + PW;

    logic [psu_pkg::ROW_PIXELS_W-1:0] r_row_pixels;
    logic [psu_pkg::IMAGE_ROWS_W-1:0] r_image_rows;
    logic [psu_pkg::BPP_W-1:0]        r_bpp;
    psu_pkg::t_reg_idx                reg_idx;
    logic                             wr_en;

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    psu_pkg::t_flags  f_flags;
    logic [7:0]       f_byte;
    logic [CW-1:0]    f_col;
    logic [PW-1:0]    f_lidx;
    logic [QW-1:0]    q_din;
    logic [QW-1:0]    q_dout;
    psu_pkg::t_flags  b_flags;
    logic [7:0]       b_byte;
    logic [CW-1:0]    b_col;
    logic [PW-1:0]    b_lidx;

    assign pready  = 1'b1;
    assign reg_idx = psu_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels <= psu_pkg::ROW_PIXELS_RST;
            r_image_rows <= psu_pkg::IMAGE_ROWS_RST;
            r_bpp        <= psu_pkg::BPP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                psu_pkg::REG_ROW_PIXELS: r_row_pixels <= pwdata[psu_pkg::ROW_PIXELS_W-1:0];
                psu_pkg::REG_IMAGE_ROWS: r_image_rows <= pwdata[psu_pkg::IMAGE_ROWS_W-1:0];
                psu_pkg::REG_BPP:        r_bpp        <= pwdata[psu_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            psu_pkg::REG_ROW_PIXELS: prdata = 32'(r_row_pixels);
            psu_pkg::REG_IMAGE_ROWS: prdata = 32'(r_image_rows);
            psu_pkg::REG_BPP:        prdata = 32'(r_bpp);
            default:                 prdata = 32'd0;
        endcase
    end

    psu_front #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .CW              (CW),
        .PW              (PW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_row_pixels (r_row_pixels),
        .i_image_rows (r_image_rows),
        .i_bpp        (r_bpp),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_flags    (f_flags),
        .o_q_byte     (f_byte),
        .o_q_col      (f_col),
        .o_q_lidx     (f_lidx)
    );

    assign q_din = {f_flags, f_byte, f_col, f_lidx};

    psu_queue #(
        .W     (QW),
        .DEPTH (psu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    assign {b_flags, b_byte, b_col, b_lidx} = q_dout;

    psu_back #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .CW              (CW),
        .PW              (PW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_flags (b_flags),
        .i_q_byte  (b_byte),
        .i_q_col   (b_col),
        .i_q_lidx  (b_lidx),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;

    typedef struct packed {
        logic [7:0] pixel;
        logic       eor;
        logic       eoi;
        logic       bad;
    } t_pixel_beat;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [psu_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    psu_in_if  in_if ();
    psu_out_if out_if ();

    png_scanline_unfilter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stream bytes waiting for the driver, and reconstructed bytes still owed by the block.
    logic [7:0]  stream_bytes [$];
    t_pixel_beat pending_pixels [$];

    int unsigned fed_cnt      = 0;
    int unsigned taken_cnt    = 0;
    int unsigned mismatches   = 0;
    int unsigned snd_idle_pct = 23;
    int unsigned rcv_idle_pct = 61;
    bit          in_beat_taken = 1'b0;
    bit          hold_off      = 1'b0;
    bit          pressure_arm  = 1'b0;

    // Shadow of the block's registers and unfilter state.
    logic [psu_pkg::ROW_PIXELS_W-1:0] cfg_row_pixels;
    logic [psu_pkg::IMAGE_ROWS_W-1:0] cfg_image_rows;
    logic [psu_pkg::BPP_W-1:0]        cfg_bpp;
    logic [7:0]                       line_store [psu_pkg::MAX_LINE_BYTES_DEF];
    logic [7:0]                       left_hist [psu_pkg::MAX_PIXEL_BYTES_DEF];
    logic [7:0]                       ul_hist [psu_pkg::MAX_PIXEL_BYTES_DEF];
    logic [12:0]                      col_cnt;
    logic [15:0]                      row_cnt;
    psu_pkg::t_filter                 row_filt;
    bit                               want_filter;
    bit                               row_bad;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic clear_predictor();
        cfg_row_pixels = psu_pkg::ROW_PIXELS_RST;
        cfg_image_rows = psu_pkg::IMAGE_ROWS_RST;
        cfg_bpp        = psu_pkg::BPP_RST;
        foreach (line_store[j]) line_store[j] = '0;
        foreach (left_hist[j]) begin
            left_hist[j] = '0;
            ul_hist[j]   = '0;
        end
        col_cnt     = '0;
        row_cnt     = '0;
        row_filt    = psu_pkg::FILT_NONE;
        want_filter = 1'b1;
        row_bad     = 1'b0;
    endtask

    function automatic int unsigned lane_bytes();
        int unsigned b;
        b = cfg_bpp;
        if (b == 0) b = 1;
        if (b > psu_pkg::MAX_PIXEL_BYTES_DEF) b = psu_pkg::MAX_PIXEL_BYTES_DEF;
        return b;
    endfunction

    function automatic int unsigned row_stride();
        int unsigned s;
        s = ((cfg_row_pixels == 0) ? 1 : cfg_row_pixels) * lane_bytes();
        if (s > psu_pkg::MAX_LINE_BYTES_DEF) s = psu_pkg::MAX_LINE_BYTES_DEF;
        return s;
    endfunction

    function automatic int unsigned image_depth();
        return (cfg_image_rows == 0) ? 1 : cfg_image_rows;
    endfunction

    function automatic int unsigned paeth_pick(input int a, input int b, input int c);
        int p;
        int da;
        int db;
        int dc;
        p  = a + b - c;
        da = (p >= a) ? p - a : a - p;
        db = (p >= b) ? p - b : b - p;
        dc = (p >= c) ? p - c : c - p;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Advances the shadow state by one stream byte; returns 1 when a pixel byte is due.
    function automatic bit unfilter_step(input logic [7:0] x, output t_pixel_beat r);
        int unsigned bpp, stride, rows, col, lft, abv, ul, pred;
        logic [7:0]  val;
        bit          first_row, have_left;
        int          i;
        r = '0;
        if (want_filter) begin
            if (x > 8'(psu_pkg::FILT_PAETH)) begin
                row_bad  = 1'b1;
                row_filt = psu_pkg::FILT_NONE;
            end else begin
                row_bad  = 1'b0;
                row_filt = psu_pkg::t_filter'(x[2:0]);
            end
            want_filter = 1'b0;
            col_cnt     = '0;
            foreach (left_hist[j]) begin
                left_hist[j] = '0;
                ul_hist[j]   = '0;
            end
            return 1'b0;
        end
        bpp       = lane_bytes();
        stride    = row_stride();
        rows      = image_depth();
        col       = col_cnt;
        first_row = (row_cnt == 0);
        have_left = (col >= bpp);
        lft = have_left ? left_hist[bpp-1] : 0;
        abv = (!first_row && col < psu_pkg::MAX_LINE_BYTES_DEF) ? line_store[col] : 0;
        ul  = (!first_row && have_left) ? ul_hist[bpp-1] : 0;
        if (row_bad) begin
            pred = 0;
        end else begin
            case (row_filt)
                psu_pkg::FILT_SUB:   pred = lft;
                psu_pkg::FILT_UP:    pred = abv;
                psu_pkg::FILT_AVG:   pred = (lft + abv) >> 1;
                psu_pkg::FILT_PAETH: pred = paeth_pick(lft, abv, ul);
                default:             pred = 0;
            endcase
        end
        val = 8'((x + pred) & psu_pkg::BYTE_MASK);
        for (i = psu_pkg::MAX_PIXEL_BYTES_DEF - 1; i > 0; i--) begin
            left_hist[i] = left_hist[i-1];
            ul_hist[i]   = ul_hist[i-1];
        end
        left_hist[0] = val;
        ul_hist[0]   = 8'(abv);
        if (col < psu_pkg::MAX_LINE_BYTES_DEF) line_store[col] = val;
        r.pixel = val;
        r.bad   = row_bad;
        r.eor   = (col + 1 >= stride);
        if (r.eor) begin
            col_cnt     = '0;
            want_filter = 1'b1;
            if (row_cnt + 1 >= rows) begin
                r.eoi   = 1'b1;
                row_cnt = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = 13'(col + 1);
        end
        return 1'b1;
    endfunction

    task automatic apb_write(input psu_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] field_mask;
        logic [31:0] got;
        case (idx)
            psu_pkg::REG_ROW_PIXELS: field_mask = (32'd1 << psu_pkg::ROW_PIXELS_W) - 1;
            psu_pkg::REG_IMAGE_ROWS: field_mask = (32'd1 << psu_pkg::IMAGE_ROWS_W) - 1;
            default:                 field_mask = (32'd1 << psu_pkg::BPP_W) - 1;
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= psu_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= (value & field_mask) | ($urandom & ~field_mask);
        @(negedge i_clk);
        penable <= 1'b1;
        // Read the register straight back; psel stays high into the read setup.
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            psu_pkg::REG_ROW_PIXELS: cfg_row_pixels = value[psu_pkg::ROW_PIXELS_W-1:0];
            psu_pkg::REG_IMAGE_ROWS: cfg_image_rows = value[psu_pkg::IMAGE_ROWS_W-1:0];
            default:                 cfg_bpp        = value[psu_pkg::BPP_W-1:0];
        endcase
        if (got !== (value & field_mask)) begin
            report_mismatch($sformatf("%s read back %0h, wrote %0h", idx.name(), got,
                                      value & field_mask));
        end
    endtask

    // Waits until every byte has gone in and every pixel byte has come out.
    task automatic settle();
        do @(negedge i_clk);
        while (taken_cnt != fed_cnt || pending_pixels.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic push_bytes(input int unsigned n);
        repeat (n) begin
            stream_bytes.push_back(8'($urandom));
            fed_cnt++;
        end
    endtask

    task automatic push_row(input logic [7:0] filt, input int unsigned n);
        stream_bytes.push_back(filt);
        fed_cnt++;
        push_bytes(n);
    endtask

    task automatic push_row3(input logic [7:0] filt, input logic [7:0] a,
                             input logic [7:0] b, input logic [7:0] c);
        stream_bytes.push_back(filt);
        stream_bytes.push_back(a);
        stream_bytes.push_back(b);
        stream_bytes.push_back(c);
        fed_cnt += 4;
    endtask

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(0, 99) < 88) begin
            return 8'($urandom_range(int'(psu_pkg::FILT_NONE), int'(psu_pkg::FILT_PAETH)));
        end
        return 8'($urandom_range(int'(psu_pkg::FILT_PAETH) + 1, 255));
    endfunction

    function automatic logic [31:0] pick_row_pixels();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Driver: a new beat goes out once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.filtered_byte <= '0;
        end else if (!in_if.valid || in_beat_taken) begin
            if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                in_if.valid         <= 1'b1;
                in_if.filtered_byte <= stream_bytes.pop_front();
            end else begin
                in_if.valid         <= 1'b0;
                in_if.filtered_byte <= 8'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !hold_off && ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Monitor: predicts on every input beat and checks every output beat.
    always @(posedge i_clk) begin : watch
        t_pixel_beat beat;
        t_pixel_beat want;
        if (!i_rst_n) begin
            in_beat_taken = 1'b0;
        end else begin
            in_beat_taken = in_if.valid && in_if.ready;
            if (in_beat_taken) begin
                taken_cnt++;
                if (unfilter_step(in_if.filtered_byte, beat)) begin
                    pending_pixels.push_back(beat);
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("output beat with no pixel byte pending");
                end else begin
                    want = pending_pixels.pop_front();
                    if (out_if.pixel_byte !== want.pixel) begin
                        report_mismatch($sformatf("pixel_byte %0h, expected %0h",
                                                  out_if.pixel_byte, want.pixel));
                    end
                    if (out_if.end_of_row !== want.eor) begin
                        report_mismatch($sformatf("end_of_row %0b, expected %0b",
                                                  out_if.end_of_row, want.eor));
                    end
                    if (out_if.end_of_image !== want.eoi) begin
                        report_mismatch($sformatf("end_of_image %0b, expected %0b",
                                                  out_if.end_of_image, want.eoi));
                    end
                    if (out_if.bad_filter !== want.bad) begin
                        report_mismatch($sformatf("bad_filter %0b, expected %0b",
                                                  out_if.bad_filter, want.bad));
                    end
                end
            end
        end
    end

    // Long receiver stall while the sender keeps going, so the block backs up.
    initial begin
        wait (pressure_arm);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("png_scanline_unfilter verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned rnd_base;
        int unsigned done;
        int unsigned k;
        int unsigned s_new;
        int unsigned r;
        in_if.valid         = 1'b0;
        in_if.filtered_byte = '0;
        out_if.ready        = 1'b0;
        clear_predictor();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One small image walking through every filter, byte extremes and a bad filter.
        apb_write(psu_pkg::REG_ROW_PIXELS, 3);
        apb_write(psu_pkg::REG_BPP, 1);
        apb_write(psu_pkg::REG_IMAGE_ROWS, 6);
        push_row3(8'(psu_pkg::FILT_NONE),  8'hFF, 8'h00, 8'hFF);
        push_row3(8'(psu_pkg::FILT_SUB),   8'h01, 8'hFF, 8'h80);
        push_row3(8'(psu_pkg::FILT_UP),    8'hFF, 8'hFF, 8'h00);
        push_row3(8'(psu_pkg::FILT_AVG),   8'h7F, 8'h80, 8'hFF);
        push_row3(8'(psu_pkg::FILT_PAETH), 8'h00, 8'hFF, 8'h01);
        push_row3(8'hFF,                   8'h12, 8'hFF, 8'h00);

        // Register values past the pixel size and stride limits with a huge row count.
        // Shrinking the row and the row count mid-row makes the next byte end the image.
        settle();
        apb_write(psu_pkg::REG_ROW_PIXELS, 8191);
        apb_write(psu_pkg::REG_BPP, 7);
        apb_write(psu_pkg::REG_IMAGE_ROWS, 65535);
        pressure_arm = 1'b1;
        push_row(pick_filter(), 60);
        settle();
        apb_write(psu_pkg::REG_ROW_PIXELS, 0);
        apb_write(psu_pkg::REG_IMAGE_ROWS, 0);
        push_bytes(1);

        rnd_base = fed_cnt;
        while (fed_cnt - rnd_base < 450) begin
            settle();
            done = fed_cnt - rnd_base;
            snd_idle_pct <= (done < 150) ? 23 : (done < 300) ? 61 : 0;
            rcv_idle_pct <= (done < 150) ? 61 : (done < 300) ? 23 : 0;
            apb_write(psu_pkg::REG_ROW_PIXELS, pick_row_pixels());
            apb_write(psu_pkg::REG_BPP, $urandom_range(0, 7));
            apb_write(psu_pkg::REG_IMAGE_ROWS, $urandom_range(0, 5));
            case ($urandom_range(0, 5))
                0: begin
                    // Shrink the stride in the middle of the first row; where the column
                    // count is then at or past the new end, the next byte ends the row.
                    if (row_stride() >= 2) begin
                        k = $urandom_range(1, row_stride() - 1);
                        push_row(pick_filter(), k);
                        settle();
                        apb_write(psu_pkg::REG_ROW_PIXELS, $urandom_range(0, 1));
                        s_new = row_stride();
                        push_bytes((k + 1 >= s_new) ? 1 : s_new - k);
                        repeat (image_depth() - 1) push_row(pick_filter(), s_new);
                    end else begin
                        repeat (image_depth()) push_row(pick_filter(), row_stride());
                    end
                end
                1: begin
                    // Cut the row count to at most the rows already done.
                    apb_write(psu_pkg::REG_IMAGE_ROWS, $urandom_range(6, 300));
                    r = $urandom_range(1, 3);
                    repeat (r) push_row(pick_filter(), row_stride());
                    settle();
                    apb_write(psu_pkg::REG_IMAGE_ROWS, $urandom_range(0, r));
                    push_row(pick_filter(), row_stride());
                end
                default: begin
                    repeat (image_depth()) push_row(pick_filter(), row_stride());
                end
            endcase
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("png_scanline_unfilter verification clean");
        end else begin
            $display("png_scanline_unfilter verification failed");
        end
        $finish;
    end

endmodule
